// ===== rtl/lcgja_pkg.sv =====
// Shared types and constants for the LCG skip-ahead block.
package lcgja_pkg;

  localparam int unsigned VALUE_BITS_DEF = 62;
  localparam int unsigned STEP_BITS_DEF  = 63;
  localparam int unsigned CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODULUS    = 3'd0,
    REG_MULTIPLIER = 3'd1,
    REG_INCREMENT  = 3'd2,
    REG_DIVISOR    = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MU_ADD = 2'd0,
    MU_MUL = 2'd1,
    MU_REM = 2'd2
  } mu_op_e;

  typedef struct packed {
    logic   start;
    mu_op_e op;
  } mu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_RED_A  = 4'd1,
    ST_RED_C  = 4'd2,
    ST_RED_X  = 4'd3,
    ST_LOOP   = 4'd4,
    ST_MUL_RA = 4'd5,
    ST_MUL_RC = 4'd6,
    ST_ADD_RC = 4'd7,
    ST_MUL_BC = 4'd8,
    ST_ADD_BC = 4'd9,
    ST_MUL_BA = 4'd10,
    ST_MUL_XR = 4'd11,
    ST_ADD_XR = 4'd12,
    ST_RED_G  = 4'd13,
    ST_OUT    = 4'd14
  } st_e;

endpackage

// ===== rtl/lcgja_mod_unit.sv =====
// Shared modular arithmetic unit: modular add, shift-and-add multiply, restoring remainder.
module lcgja_mod_unit #(
  parameter int unsigned W = lcgja_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcgja_pkg::mu_req_t req_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  input  logic [W-1:0]       m_i,
  output logic               done_o,
  output logic [W-1:0]       result_o
);

  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     acc_q, x_q, y_q, m_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  lcgja_pkg::mu_op_e op_q;

  logic [W-1:0] p, q, r;
  logic         cin;
  logic [W:0]   sum_a, diff_a, sum_b, diff_b;
  logic [W-1:0] red_a, red_b;

  // One adder with compare-subtract serves all three operations; a second one doubles the multiplicand.
  always_comb begin
    p   = a_i;
    q   = b_i;
    r   = m_i;
    cin = 1'b0;
    if (busy_q && op_q == lcgja_pkg::MU_REM) begin
      p   = acc_q;
      q   = acc_q;
      r   = y_q;
      cin = x_q[W-1];
    end else if (busy_q) begin
      p = acc_q;
      q = x_q;
      r = m_q;
    end
    sum_a  = {1'b0, p} + {1'b0, q} + {{W{1'b0}}, cin};
    diff_a = sum_a - {1'b0, r};
    red_a  = (sum_a >= {1'b0, r}) ? diff_a[W-1:0] : sum_a[W-1:0];
    sum_b  = {1'b0, x_q} + {1'b0, x_q};
    diff_b = sum_b - {1'b0, m_q};
    red_b  = (sum_b >= {1'b0, m_q}) ? diff_b[W-1:0] : sum_b[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= lcgja_pkg::MU_ADD;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          op_q <= req_i.op;
          case (req_i.op)
            lcgja_pkg::MU_ADD: done_q <= 1'b1;
            lcgja_pkg::MU_MUL: busy_q <= 1'b1;
            lcgja_pkg::MU_REM: busy_q <= 1'b1;
            default:           done_q <= 1'b1;
          endcase
        end
      end else if (op_q == lcgja_pkg::MU_REM) begin
        if (cnt_q == CNT_W'(W-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (y_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        acc_q <= (req_i.op == lcgja_pkg::MU_ADD) ? red_a : '0;
        x_q   <= a_i;
        y_q   <= b_i;
        m_q   <= m_i;
        cnt_q <= '0;
      end
    end else if (op_q == lcgja_pkg::MU_REM) begin
      acc_q <= red_a;
      x_q   <= {x_q[W-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end else if (y_q != '0) begin
      if (y_q[0]) begin
        acc_q <= red_a;
      end
      x_q <= red_b;
      y_q <= {1'b0, y_q[W-1:1]};
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

// ===== rtl/lcg_jump_ahead.sv =====
// LCG skip-ahead top level: configuration, sequencer and stream handshakes.
//
//  Channel   Direction  Signals                          Payload
//  s_axis    in         s_axis_tvalid/tready/tdata       seed, steps
//  m_axis    out        m_axis_tvalid/tready/tdata       result
//  cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i  modulus, multiplier, increment, divisor
//
// One request first reduces the multiplier, the increment and the seed by the modulus, then
// walks the bits of steps from the lowest up to the highest set bit, updating the result map
// on each set bit and squaring the base map on every bit, and finishes by applying the map to
// the seed and reducing by a nonzero divisor. A multiply ends early when its second operand has few bits.
// Request time is set by the single shared modular unit, which retires one operand bit per cycle.
// The input side is ready only while the sequencer is idle; a finished result waits in the
// output register, so a new request is taken while the previous result is still stalled.
// Reset returns the configuration registers to modulus 1, multiplier 0, increment 0 and divisor 1 and idles the block.
module lcg_jump_ahead #(
  parameter int unsigned VALUE_BITS = lcgja_pkg::VALUE_BITS_DEF,
  parameter int unsigned STEP_BITS  = lcgja_pkg::STEP_BITS_DEF,
  localparam int unsigned IN_W      = ((VALUE_BITS + STEP_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_W-1:0]                    s_axis_tdata,  // seed, steps
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata,  // result
  input  logic                               cfg_we_i,
  input  logic [lcgja_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [VALUE_BITS-1:0]              cfg_data_i
);

  localparam int unsigned W = VALUE_BITS;
  localparam int unsigned S = STEP_BITS;

  logic [W-1:0] modulus_q, multiplier_q, increment_q, divisor_q;
  logic [W-1:0] ba_q, bc_q, ra_q, rc_q, x0_q, t_q, res_q;
  logic [S-1:0] n_q;
  logic         out_valid_q, issued_q;
  lcgja_pkg::st_e state_q, state_d;

  lcgja_pkg::mu_req_t mu_req;
  logic [W-1:0]       mu_a, mu_b, mu_res;
  logic               mu_done, is_op, accept, out_load;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == lcgja_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= W'(1);
      multiplier_q <= '0;
      increment_q  <= '0;
      divisor_q    <= W'(1);
    end else if (cfg_we_i) begin
      case (lcgja_pkg::cfg_reg_e'(cfg_idx_i))
        lcgja_pkg::REG_MODULUS:    modulus_q    <= cfg_data_i;
        lcgja_pkg::REG_MULTIPLIER: multiplier_q <= cfg_data_i;
        lcgja_pkg::REG_INCREMENT:  increment_q  <= cfg_data_i;
        lcgja_pkg::REG_DIVISOR:    divisor_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcgja_pkg::ST_IDLE:
        if (accept) begin
          state_d = (modulus_q == '0) ? lcgja_pkg::ST_OUT : lcgja_pkg::ST_RED_A;
        end
      lcgja_pkg::ST_RED_A:  if (mu_done) state_d = lcgja_pkg::ST_RED_C;
      lcgja_pkg::ST_RED_C:  if (mu_done) state_d = lcgja_pkg::ST_RED_X;
      lcgja_pkg::ST_RED_X:  if (mu_done) state_d = lcgja_pkg::ST_LOOP;
      lcgja_pkg::ST_LOOP:
        if (n_q == '0) begin
          state_d = lcgja_pkg::ST_MUL_XR;
        end else if (n_q[0]) begin
          state_d = lcgja_pkg::ST_MUL_RA;
        end else begin
          state_d = lcgja_pkg::ST_MUL_BC;
        end
      lcgja_pkg::ST_MUL_RA: if (mu_done) state_d = lcgja_pkg::ST_MUL_RC;
      lcgja_pkg::ST_MUL_RC: if (mu_done) state_d = lcgja_pkg::ST_ADD_RC;
      lcgja_pkg::ST_ADD_RC: if (mu_done) state_d = lcgja_pkg::ST_MUL_BC;
      lcgja_pkg::ST_MUL_BC: if (mu_done) state_d = lcgja_pkg::ST_ADD_BC;
      lcgja_pkg::ST_ADD_BC: if (mu_done) state_d = lcgja_pkg::ST_MUL_BA;
      lcgja_pkg::ST_MUL_BA: if (mu_done) state_d = lcgja_pkg::ST_LOOP;
      lcgja_pkg::ST_MUL_XR: if (mu_done) state_d = lcgja_pkg::ST_ADD_XR;
      lcgja_pkg::ST_ADD_XR:
        if (mu_done) begin
          state_d = (divisor_q != '0) ? lcgja_pkg::ST_RED_G : lcgja_pkg::ST_OUT;
        end
      lcgja_pkg::ST_RED_G:  if (mu_done) state_d = lcgja_pkg::ST_OUT;
      lcgja_pkg::ST_OUT:    if (out_load) state_d = lcgja_pkg::ST_IDLE;
      default:              state_d = lcgja_pkg::ST_IDLE;
    endcase
  end

  // Operation and operands for the shared unit in each state.
  always_comb begin
    is_op     = 1'b1;
    mu_req.op = lcgja_pkg::MU_MUL;
    mu_a      = '0;
    mu_b      = '0;
    case (state_q)
      lcgja_pkg::ST_RED_A: begin
        mu_req.op = lcgja_pkg::MU_REM; mu_a = multiplier_q; mu_b = modulus_q;
      end
      lcgja_pkg::ST_RED_C: begin
        mu_req.op = lcgja_pkg::MU_REM; mu_a = increment_q; mu_b = modulus_q;
      end
      lcgja_pkg::ST_RED_X: begin
        mu_req.op = lcgja_pkg::MU_REM; mu_a = x0_q; mu_b = modulus_q;
      end
      lcgja_pkg::ST_MUL_RA: begin mu_a = ra_q; mu_b = ba_q; end
      lcgja_pkg::ST_MUL_RC: begin mu_a = rc_q; mu_b = ba_q; end
      lcgja_pkg::ST_ADD_RC: begin
        mu_req.op = lcgja_pkg::MU_ADD; mu_a = t_q; mu_b = bc_q;
      end
      lcgja_pkg::ST_MUL_BC: begin mu_a = bc_q; mu_b = ba_q; end
      lcgja_pkg::ST_ADD_BC: begin
        mu_req.op = lcgja_pkg::MU_ADD; mu_a = t_q; mu_b = bc_q;
      end
      lcgja_pkg::ST_MUL_BA: begin mu_a = ba_q; mu_b = ba_q; end
      lcgja_pkg::ST_MUL_XR: begin mu_a = x0_q; mu_b = ra_q; end
      lcgja_pkg::ST_ADD_XR: begin
        mu_req.op = lcgja_pkg::MU_ADD; mu_a = t_q; mu_b = rc_q;
      end
      lcgja_pkg::ST_RED_G: begin
        mu_req.op = lcgja_pkg::MU_REM; mu_a = t_q; mu_b = divisor_q;
      end
      default: is_op = 1'b0;
    endcase
    mu_req.start = is_op && !issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgja_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mu_done) begin
        issued_q <= 1'b0;
      end else if (mu_req.start) begin
        issued_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q <= s_axis_tdata[W-1:0];
      n_q  <= s_axis_tdata[W+S-1:W];
      ra_q <= (modulus_q == W'(1)) ? '0 : W'(1);
      rc_q <= '0;
      t_q  <= '0;
    end
    if (out_load) begin
      res_q <= t_q;
    end
    if (mu_done) begin
      case (state_q)
        lcgja_pkg::ST_RED_A:  ba_q <= mu_res;
        lcgja_pkg::ST_RED_C:  bc_q <= mu_res;
        lcgja_pkg::ST_RED_X:  x0_q <= mu_res;
        lcgja_pkg::ST_MUL_RA: ra_q <= mu_res;
        lcgja_pkg::ST_ADD_RC: rc_q <= mu_res;
        lcgja_pkg::ST_ADD_BC: bc_q <= mu_res;
        lcgja_pkg::ST_MUL_BA: begin
          ba_q <= mu_res;
          n_q  <= n_q >> 1;
        end
        default: t_q <= mu_res;
      endcase
    end
  end

  lcgja_mod_unit #(
    .W(W)
  ) u_mod_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mu_req),
    .a_i      (mu_a),
    .b_i      (mu_b),
    .m_i      (modulus_q),
    .done_o   (mu_done),
    .result_o (mu_res)
  );

  assign s_axis_tready = (state_q == lcgja_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(res_q);

  // The unit only finishes work that the sequencer asked for.
  a_done_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_done |-> (state_q != lcgja_pkg::ST_IDLE && state_q != lcgja_pkg::ST_LOOP &&
                 state_q != lcgja_pkg::ST_OUT))
    else $error("modular unit finished outside an operation state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != lcgja_pkg::ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_step_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcgja_pkg::ST_MUL_BA && mu_done) |=> n_q == ($past(n_q) >> 1))
    else $error("step count not shifted after squaring the base map");

  a_one_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_req.start |=> !mu_req.start)
    else $error("operation issued twice in a row");

endmodule

// ===== test/lcg_jump_ahead_tb.sv =====
// Self-checking testbench for the LCG skip-ahead block with random stream stalls.
module lcg_jump_ahead_tb;

  localparam logic [63:0] VAL_MAX  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] STEP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [lcgja_pkg::CFG_IDX_BITS-1:0] CFG_IDX_UNMAPPED = 3'd6;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 20;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;  // seed [61:0], steps [124:62]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;  // result [61:0]
  logic         cfg_we_i;
  logic [lcgja_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [61:0]  cfg_data_i;

  // Generator settings as the block should currently hold them.
  logic [63:0] gen_modulus;
  logic [63:0] gen_multiplier;
  logic [63:0] gen_increment;
  logic [63:0] gen_divisor;

  logic [63:0] pending_results[$];
  logic [63:0] expected_result;
  int error_count;
  int idle_cycles;
  int gap_pct;
  int stall_pct;
  int stall_left;

  lcg_jump_ahead dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mod_add(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [63:0] s;
    s = x + y;
    if (s >= m) s = s - m;
    return s;
  endfunction

  function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    while (y != 0) begin
      if (y[0]) acc = mod_add(acc, x, m);
      x = mod_add(x, x, m);
      y = y >> 1;
    end
    return acc;
  endfunction

  // The n-step map x -> A*x + C is built by squaring the one-step map over the bits of n.
  function automatic logic [63:0] jump_state(input logic [63:0] seed, input logic [63:0] steps);
    logic [63:0] m;
    logic [63:0] ba;
    logic [63:0] bc;
    logic [63:0] ra;
    logic [63:0] rc;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] res;
    m = gen_modulus;
    n = steps & STEP_MAX;
    x = seed & VAL_MAX;
    res = '0;
    if (m != 0) begin
      ba = gen_multiplier % m;
      bc = gen_increment % m;
      ra = 64'd1 % m;
      rc = '0;
      x = x % m;
      while (n != 0) begin
        if (n[0]) begin
          ra = mod_mul(ra, ba, m);
          rc = mod_add(mod_mul(rc, ba, m), bc, m);
        end
        bc = mod_add(mod_mul(bc, ba, m), bc, m);
        ba = mod_mul(ba, ba, m);
        n = n >> 1;
      end
      res = mod_add(mod_mul(x, ra, m), rc, m);
      if (gen_divisor != 0) res = res % gen_divisor;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_delay();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic cfg_write(input logic [lcgja_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value[61:0];
    case (lcgja_pkg::cfg_reg_e'(idx))
      lcgja_pkg::REG_MODULUS:    gen_modulus = value & VAL_MAX;
      lcgja_pkg::REG_MULTIPLIER: gen_multiplier = value & VAL_MAX;
      lcgja_pkg::REG_INCREMENT:  gen_increment = value & VAL_MAX;
      lcgja_pkg::REG_DIVISOR:    gen_divisor = value & VAL_MAX;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_generator(input logic [63:0] m, input logic [63:0] a,
                               input logic [63:0] c, input logic [63:0] g);
    cfg_write(lcgja_pkg::REG_MODULUS, m);
    cfg_write(lcgja_pkg::REG_MULTIPLIER, a);
    cfg_write(lcgja_pkg::REG_INCREMENT, c);
    cfg_write(lcgja_pkg::REG_DIVISOR, g);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [63:0] seed, input logic [63:0] steps);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_delay() : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {3'b000, steps[62:0], seed[61:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(jump_state(seed, steps));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_reset_defaults();
    // Reset leaves modulus 1, so every state collapses to zero.
    send_request(VAL_MAX, STEP_MAX);
    send_request(64'd12345, 64'd0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_generator(VAL_MAX, VAL_MAX, VAL_MAX, 64'd0);
    send_request(VAL_MAX, 64'd0);
    send_request(VAL_MAX, STEP_MAX);
    send_request(64'd0, 64'd1);
    wait_idle();
    set_generator(VAL_MAX, VAL_MAX - 1, VAL_MAX - 1, 64'd0);
    send_request(VAL_MAX - 1, STEP_MAX);
    send_request(64'd1, 64'd1);
    send_request(64'd0, 64'd2);
    wait_idle();
    // A unit multiplier turns the generator into a plain counter.
    set_generator(VAL_MAX, 64'd1, 64'd1, VAL_MAX);
    send_request(64'd5, 64'd1000);
    send_request(VAL_MAX - 2, 64'd3);
    wait_idle();
  endtask

  task automatic test_special_cases();
    set_generator(64'd0, 64'd7, 64'd3, 64'd0);
    send_request(VAL_MAX, STEP_MAX);
    send_request(64'd9, 64'd0);
    wait_idle();
    set_generator(64'd1000, 64'd7, 64'd3, 64'd13);
    send_request(VAL_MAX, 64'd0);
    send_request(64'd999, 64'd1);
    send_request(64'd123, 64'd77);
    wait_idle();
    // Writes to an unmapped index must leave the generator untouched.
    cfg_write(CFG_IDX_UNMAPPED, 64'd0);
    send_request(64'd456, 64'd300);
    wait_idle();
    cfg_write(lcgja_pkg::REG_DIVISOR, 64'd1);
    send_request(64'd77, 64'd5);
    wait_idle();
    cfg_write(lcgja_pkg::REG_MODULUS, 64'd1 << 61);
    send_request(VAL_MAX, STEP_MAX - 1);
    wait_idle();
  endtask

  function automatic logic [63:0] random_modulus();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(1, 1000));
      1: return rand64() & VAL_MAX;
      2: return VAL_MAX;
      3: return 64'd1 << $urandom_range(0, 61);
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] random_divisor();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'($urandom_range(1, 100));
      2: return rand64() & VAL_MAX;
      default: return 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] random_steps();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return STEP_MAX;
    if (pick < 17) return rand64() & STEP_MAX;
    // Short step counts keep most requests cheap.
    return rand64() & ((64'd1 << $urandom_range(0, 12)) - 1);
  endfunction

  function automatic logic [63:0] random_seed();
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return VAL_MAX;
      default: return rand64() & VAL_MAX;
    endcase
  endfunction

  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_generator(random_modulus(), rand64() & VAL_MAX, rand64() & VAL_MAX, random_divisor());
      // The first phase runs with no idling at all on either side.
      gap_pct = (phase == 0) ? 0 : $urandom_range(10, 60);
      stall_pct = (phase == 0) ? 0 : $urandom_range(10, 60);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_request(random_seed(), random_steps());
      wait_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = lcgja_pkg::REG_MODULUS;
    cfg_data_i = '0;
    gen_modulus = 64'd1;
    gen_multiplier = '0;
    gen_increment = '0;
    gen_divisor = 64'd1;
    error_count = 0;
    gap_pct = 30;
    stall_pct = 30;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_special_cases();
    test_random_phases();
    wait_idle();
    repeat (200) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_delay();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request pending", m_axis_tdata[61:0]));
      end else begin
        expected_result = pending_results.pop_front();
        if (m_axis_tdata[61:0] !== expected_result[61:0])
          report_mismatch($sformatf("result got %0d expected %0d", m_axis_tdata[61:0],
                                    expected_result[61:0]));
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lcgja_pkg.sv
rtl/lcgja_mod_unit.sv
rtl/lcg_jump_ahead.sv
test/lcg_jump_ahead_tb.sv
